// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VBE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("vbe assertion failed");

// Condition that must be followed by another one on the next edge.
`define VBE_ASSERT_NEXT(label, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("vbe assertion failed");

`endif

// ===== hw/rtl/vbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vbe_pkg;

	localparam int DEF_PEER_SLOTS = 16;
	localparam int DEF_LIST_DEPTH = 8;

	localparam logic [31:0] RST_WINDOW_MS   = 32'd10000;
	localparam logic [7:0]  RST_LIMIT       = 8'd5;
	localparam logic [31:0] RST_EXPIRE_MS   = 32'd60000;
	localparam logic [7:0]  RST_BCAST       = 8'd255;
	localparam logic [7:0]  COUNT_MAX       = 8'd255;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_LIMIT  = 2'd1;
	localparam logic [1:0] REG_EXPIRE = 2'd2;
	localparam logic [1:0] REG_BCAST  = 2'd3;

	localparam logic [1:0] STAT_QUERY   = 2'd0;
	localparam logic [1:0] STAT_COUNTED = 2'd1;
	localparam logic [1:0] STAT_IGNORED = 2'd2;

	localparam logic KIND_VIOLATION = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_LOOKUP,
		ST_COUNT,
		ST_LIST,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic sweep_step;
		logic lookup;
		logic count;
		logic list_upd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic expired;
		logic reached;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vbe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vbe_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire vbe_pkg::sts_t sts,
	output vbe_pkg::cmd_t      cmd
);

	vbe_pkg::state_t state_q, state_nx;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vbe_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			vbe_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nx = vbe_pkg::ST_SWEEP;
				end
			end
			vbe_pkg::ST_SWEEP: begin
				// One expired entry is removed per cycle until none remain.
				if (sts.expired) begin
					cmd.sweep_step = 1'b1;
				end else begin
					state_nx = vbe_pkg::ST_LOOKUP;
				end
			end
			vbe_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_nx = vbe_pkg::ST_COUNT;
			end
			vbe_pkg::ST_COUNT: begin
				cmd.count = 1'b1;
				state_nx = vbe_pkg::ST_LIST;
			end
			vbe_pkg::ST_LIST: begin
				cmd.list_upd = sts.reached;
				state_nx = vbe_pkg::ST_FINISH;
			end
			vbe_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_nx = vbe_pkg::ST_IDLE;
				end
			end
			default: state_nx = vbe_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/vbe_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vbe_datapath #(
	parameter int PEER_SLOTS = vbe_pkg::DEF_PEER_SLOTS,
	parameter int LIST_DEPTH = vbe_pkg::DEF_LIST_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_data,
	input  wire logic          kind,
	input  wire logic [7:0]    node_addr,
	input  wire logic [31:0]   now_ms,
	input  wire vbe_pkg::cmd_t cmd,
	output vbe_pkg::sts_t      sts,
	output logic               is_listed,
	output logic [3:0]         list_count,
	output logic [7:0]         peer_violations,
	output logic [1:0]         status
);

	localparam int SW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int LW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int FW = $clog2(LIST_DEPTH + 1);

	logic [31:0] window_q, expire_q;
	logic [7:0]  limit_q, bcast_q;

	logic        kind_q;
	logic [7:0]  addr_q;
	logic [31:0] now_q;

	logic        slot_used_q  [PEER_SLOTS];
	logic [7:0]  slot_addr_q  [PEER_SLOTS];
	logic [7:0]  slot_cnt_q   [PEER_SLOTS];
	logic [31:0] slot_start_q [PEER_SLOTS];

	logic [7:0]  list_addr_q [LIST_DEPTH];
	logic [31:0] list_exp_q  [LIST_DEPTH];
	logic [FW-1:0] fill_q;

	logic [SW-1:0] slot_idx_q;
	logic        hit_q, do_count_q, reached_q;
	logic [7:0]  pv_q;
	logic [1:0]  stat_q;

	// Sweep: first expired live entry.
	logic [LIST_DEPTH-1:0] expd;
	logic [LW-1:0] exp_idx;
	// Peer lookup.
	logic          p_hit, p_free;
	logic [SW-1:0] p_hidx, p_fidx;
	// List lookup.
	logic          l_hit;
	logic [LW-1:0] l_idx;
	// Counting.
	logic [7:0]  cur_cnt, base_cnt, new_cnt;
	logic [31:0] cur_start;
	logic        restart;

	always_comb begin
		exp_idx = '0;
		for (int j = LIST_DEPTH - 1; j >= 0; j--) begin
			expd[j] = (FW'(j) < fill_q) && (list_exp_q[j] != 32'd0) && (list_exp_q[j] <= now_q);
			if (expd[j]) begin
				exp_idx = LW'(j);
			end
		end
	end

	always_comb begin
		p_hit = 1'b0;
		p_free = 1'b0;
		p_hidx = '0;
		p_fidx = '0;
		for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
			if (slot_used_q[i] && slot_addr_q[i] == addr_q) begin
				p_hit = 1'b1;
				p_hidx = SW'(i);
			end
			if (!slot_used_q[i]) begin
				p_free = 1'b1;
				p_fidx = SW'(i);
			end
		end
	end

	always_comb begin
		l_hit = 1'b0;
		l_idx = '0;
		for (int j = LIST_DEPTH - 1; j >= 0; j--) begin
			if ((FW'(j) < fill_q) && list_addr_q[j] == addr_q) begin
				l_hit = 1'b1;
				l_idx = LW'(j);
			end
		end
	end

	// A freshly allocated slot starts with count and window start at zero.
	always_comb begin
		cur_cnt = hit_q ? slot_cnt_q[slot_idx_q] : 8'd0;
		cur_start = hit_q ? slot_start_q[slot_idx_q] : 32'd0;
		restart = (now_q - cur_start) > window_q;
		base_cnt = restart ? 8'd0 : cur_cnt;
		new_cnt = (base_cnt == vbe_pkg::COUNT_MAX) ? base_cnt : base_cnt + 8'd1;
	end

	assign sts.expired = |expd;
	assign sts.reached = reached_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= vbe_pkg::RST_WINDOW_MS;
			limit_q <= vbe_pkg::RST_LIMIT;
			expire_q <= vbe_pkg::RST_EXPIRE_MS;
			bcast_q <= vbe_pkg::RST_BCAST;
			fill_q <= '0;
			for (int i = 0; i < PEER_SLOTS; i++) begin
				slot_used_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					vbe_pkg::REG_WINDOW: window_q <= cfg_data;
					vbe_pkg::REG_LIMIT:  limit_q <= cfg_data[7:0];
					vbe_pkg::REG_EXPIRE: expire_q <= cfg_data;
					vbe_pkg::REG_BCAST:  bcast_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.count && do_count_q) begin
				slot_used_q[slot_idx_q] <= 1'b1;
			end
			if (cmd.sweep_step) begin
				fill_q <= fill_q - FW'(1);
			end else if (cmd.list_upd && !l_hit && fill_q < FW'(LIST_DEPTH)) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind;
			addr_q <= node_addr;
			now_q <= now_ms;
		end
		if (cmd.lookup) begin
			hit_q <= p_hit;
			slot_idx_q <= p_hit ? p_hidx : p_fidx;
			do_count_q <= (kind_q == vbe_pkg::KIND_VIOLATION) && (addr_q != bcast_q)
				&& (p_hit || p_free);
			if (kind_q != vbe_pkg::KIND_VIOLATION) begin
				stat_q <= vbe_pkg::STAT_QUERY;
			end else if ((addr_q != bcast_q) && (p_hit || p_free)) begin
				stat_q <= vbe_pkg::STAT_COUNTED;
			end else begin
				stat_q <= vbe_pkg::STAT_IGNORED;
			end
		end
		if (cmd.count) begin
			reached_q <= do_count_q && (new_cnt >= limit_q);
			pv_q <= do_count_q ? new_cnt : cur_cnt;
			if (do_count_q) begin
				slot_addr_q[slot_idx_q] <= addr_q;
				slot_cnt_q[slot_idx_q] <= new_cnt;
				slot_start_q[slot_idx_q] <= restart ? now_q : cur_start;
			end
		end
		if (cmd.sweep_step) begin
			for (int j = 0; j < LIST_DEPTH - 1; j++) begin
				if (LW'(j) >= exp_idx) begin
					list_addr_q[j] <= list_addr_q[j+1];
					list_exp_q[j] <= list_exp_q[j+1];
				end
			end
		end else if (cmd.list_upd) begin
			if (l_hit) begin
				list_exp_q[l_idx] <= now_q + expire_q;
			end else if (fill_q >= FW'(LIST_DEPTH)) begin
				// Full list: drop the oldest entry and append at the tail.
				for (int j = 0; j < LIST_DEPTH - 1; j++) begin
					list_addr_q[j] <= list_addr_q[j+1];
					list_exp_q[j] <= list_exp_q[j+1];
				end
				list_addr_q[LIST_DEPTH-1] <= addr_q;
				list_exp_q[LIST_DEPTH-1] <= now_q + expire_q;
			end else begin
				list_addr_q[fill_q[LW-1:0]] <= addr_q;
				list_exp_q[fill_q[LW-1:0]] <= now_q + expire_q;
			end
		end
		if (cmd.load_out) begin
			is_listed <= l_hit;
			list_count <= 4'(fill_q);
			peer_violations <= pv_q;
			status <= stat_q;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/violation_blacklist_engine_core.sv =====
// Violation counter with an expiring blacklist.
// Input channel: in_valid / in_stall carry one request (kind, node_addr,
// now_ms). A query only reports; a violation not to the broadcast address is
// counted against the address's peer slot (if one is held or free) and may put
// the address on the blacklist. Output channel: out_valid / out_stall carry
// one result per request (is_listed, list_count, peer_violations, status).
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (0 window, 1 limit, 2 expiry, 3 broadcast address).
// Before the lookup, the sweep removes one expired blacklist entry per cycle
// until none remain; at most LIST_DEPTH entries expire on one request. A
// new request is taken once the previous one has been written to the output
// register and the control is back in its idle state; the result may wait
// under stall while the next request is processed.
// Under a stalled output the result holds and a finished request waits in
// the final state. Reset empties the peer table and the blacklist and
// loads the default register values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module violation_blacklist_engine_core #(
	parameter int PEER_SLOTS = vbe_pkg::DEF_PEER_SLOTS,
	parameter int LIST_DEPTH = vbe_pkg::DEF_LIST_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  node_addr,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             is_listed,
	output logic [3:0]       list_count,
	output logic [7:0]       peer_violations,
	output logic [1:0]       status
);

	vbe_pkg::cmd_t cmd;
	vbe_pkg::sts_t sts;

	vbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vbe_datapath #(
		.PEER_SLOTS (PEER_SLOTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.kind            (kind),
		.node_addr       (node_addr),
		.now_ms          (now_ms),
		.cmd             (cmd),
		.sts             (sts),
		.is_listed       (is_listed),
		.list_count      (list_count),
		.peer_violations (peer_violations),
		.status          (status)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/vbe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vbe_checker #(
	parameter int LIST_DEPTH = vbe_pkg::DEF_LIST_DEPTH
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_we,
	input wire logic [1:0]  cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        kind,
	input wire logic [7:0]  node_addr,
	input wire logic [31:0] now_ms,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        is_listed,
	input wire logic [3:0]  list_count,
	input wire logic [7:0]  peer_violations,
	input wire logic [1:0]  status
);

	logic unused_ok;
	assign unused_ok = cfg_we ^ (^cfg_index) ^ (^cfg_data) ^ kind ^ (^node_addr)
		^ (^now_ms) ^ (^peer_violations);

	// The block works on one request at a time.
	`VBE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`VBE_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
	`VBE_ASSERT(a_status_code, !out_valid || status == vbe_pkg::STAT_QUERY
		|| status == vbe_pkg::STAT_COUNTED || status == vbe_pkg::STAT_IGNORED)
	// A listed address implies a non-empty list.
	`VBE_ASSERT(a_listed_count, !(out_valid && is_listed && LIST_DEPTH < 16)
		|| list_count != 4'd0)

endmodule

bind violation_blacklist_engine_core vbe_checker #(.LIST_DEPTH(LIST_DEPTH)) u_chk (.*);
`default_nettype wire
